// ----- src/ffp_pkg.sv -----
// ----------------------------------------------------------------------------
// FFP adder package
// Payload types and encoding constants shared by the FFP adder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffp_pkg;

    localparam int unsigned FarApart = 31;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } ffp_in_t;

    typedef struct packed {
        logic [31:0] sum_word;
        logic        zero_flag;
        logic        negative_flag;
        logic        overflow_flag;
    } ffp_out_t;

    // Aligned operands handed from the front to the back.
    typedef struct packed {
        logic [31:0] ma;
        logic [31:0] mb;
        logic        sign_a;
        logic        same_sign;
        logic [7:0]  exp;       // larger exponent plus one, 1..128
    } ffp_align_t;

endpackage : ffp_pkg

`default_nettype wire

// ----- src/ffp_float_adder.sv -----
// ----------------------------------------------------------------------------
// FFP float adder
// Adds two FFP words and returns the sum with zero, negative, overflow flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_data carries operand_a and operand_b; a beat moves on s_valid && s_ready.
//   m_data carries sum_word and the three flags; a beat moves on
//   m_valid && m_ready.
//   A result passes the front register (exponent compare and alignment),
//   an entry of the two-entry queue, and the back register (add,
//   leading-one normalize, pack).
//   Throughput is one item per cycle while m_ready stays high.
//   When the receiver stalls, the back register holds its result, the queue
//   fills, and s_ready drops once the front register can no longer advance.
//   No results are dropped or repeated.
//   Reset clears all valid state, so s_ready is high when aresetn
//   rises and the block accepts beats from then on.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_float_adder
    import ffp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ffp_in_t  s_data,
    input  wire logic     s_valid,
    output logic          s_ready,
    output ffp_out_t      m_data,
    output logic          m_valid,
    input  wire logic     m_ready
);

    ffp_align_t f_data, b_data;
    logic       f_valid, f_ready, b_valid, b_ready;

    ffp_front u_front (
        .aclk, .aresetn, .s_data, .s_valid, .s_ready,
        .q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
    );

    ffp_queue u_queue (
        .aclk, .aresetn,
        .in_data(f_data), .in_valid(f_valid), .in_ready(f_ready),
        .out_data(b_data), .out_valid(b_valid), .out_ready(b_ready)
    );

    ffp_back u_back (
        .aclk, .aresetn,
        .q_data(b_data), .q_valid(b_valid), .q_ready(b_ready),
        .m_data, .m_valid, .m_ready
    );

    a_zero_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_flag |-> !m_data.overflow_flag && !m_data.negative_flag)
        else $error("zero result with other flags");

    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_flag |-> m_data.sum_word == 32'd0)
        else $error("zero flag with nonzero word");

    a_neg_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_flag |-> m_data.negative_flag == m_data.sum_word[7])
        else $error("negative flag differs from sign");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow_flag |-> m_data.sum_word[6:0] == 7'h7F)
        else $error("overflow without saturation");

endmodule : ffp_float_adder

`default_nettype wire

// ----- src/ffp_front.sv -----
// ----------------------------------------------------------------------------
// FFP adder front end
// Accepts operand pairs, compares exponents and aligns the mantissas.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_front
    import ffp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ffp_in_t    s_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    output ffp_align_t      q_data,
    output logic            q_valid,
    input  wire logic       q_ready
);

    logic       valid_reg;
    ffp_align_t data_reg;
    ffp_align_t data_next;

    logic [6:0] ea, eb;
    logic [7:0] diff_ab, diff_ba;
    logic [31:0] ma, mb;

    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        ea = s_data.operand_a[6:0];
        eb = s_data.operand_b[6:0];
        ma = {s_data.operand_a[31:8], 8'd0};
        mb = {s_data.operand_b[31:8], 8'd0};
        diff_ab = {1'b0, ea} - {1'b0, eb};
        diff_ba = {1'b0, eb} - {1'b0, ea};
        data_next.sign_a    = s_data.operand_a[7];
        data_next.same_sign = s_data.operand_a[7] == s_data.operand_b[7];
        if (ea > eb) begin
            data_next.mb  = (diff_ab >= 8'(FarApart)) ? 32'd0 : (mb >> (diff_ab[4:0] + 5'd1));
            data_next.ma  = ma >> 1;
            data_next.exp = {1'b0, ea} + 8'd1;
        end else begin
            data_next.ma  = (diff_ba >= 8'(FarApart)) ? 32'd0 : (ma >> (diff_ba[4:0] + 5'd1));
            data_next.mb  = mb >> 1;
            data_next.exp = {1'b0, eb} + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule : ffp_front

`default_nettype wire

// ----- src/ffp_queue.sv -----
// ----------------------------------------------------------------------------
// FFP adder queue
// Two-entry queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_queue
    import ffp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ffp_align_t in_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    output ffp_align_t      out_data,
    output logic            out_valid,
    input  wire logic       out_ready
);

    ffp_align_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule : ffp_queue

`default_nettype wire

// ----- src/ffp_back.sv -----
// ----------------------------------------------------------------------------
// FFP adder back end
// Adds or subtracts aligned mantissas, normalizes and packs the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_back
    import ffp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ffp_align_t q_data,
    input  wire logic       q_valid,
    output logic            q_ready,
    output ffp_out_t        m_data,
    output logic            m_valid,
    input  wire logic       m_ready
);

    logic     valid_reg;
    ffp_out_t data_reg;
    ffp_out_t data_next;

    logic [31:0] m, diff;
    logic [5:0]  lz;
    logic [8:0]  exp;   // signed two's complement, -30..128
    logic        sign;
    logic        found;

    assign q_ready = !valid_reg || m_ready;

    always_comb begin
        lz    = 6'd0;
        found = 1'b0;
        diff  = 32'd0;
        exp   = {1'b0, q_data.exp};
        if (q_data.same_sign) begin
            sign = q_data.sign_a;
            m    = q_data.ma + q_data.mb;
            if (m != 32'd0 && !m[31]) begin
                exp = exp - 9'd1;
                m   = m << 1;
            end
        end else begin
            diff = q_data.sign_a ? (q_data.mb - q_data.ma) : (q_data.ma - q_data.mb);
            sign = diff[31];
            m    = diff[31] ? (32'd0 - diff) : diff;
            // priority encode the leading one
            for (int i = 31; i >= 0; i--) begin
                if (!found && m[i]) begin
                    found = 1'b1;
                    lz    = 6'(31 - i);
                end
            end
            m   = m << lz;
            exp = exp - {3'd0, lz};
        end
        if (m == 32'd0) begin
            data_next = '{sum_word: 32'd0, zero_flag: 1'b1,
                          negative_flag: 1'b0, overflow_flag: 1'b0};
        end else if (exp[8] || exp[7]) begin
            data_next = '{sum_word: {24'hFFFFFF, sign, 7'h7F}, zero_flag: 1'b0,
                          negative_flag: sign, overflow_flag: 1'b1};
        end else begin
            data_next = '{sum_word: {m[31:8], sign, exp[6:0]}, zero_flag: 1'b0,
                          negative_flag: sign, overflow_flag: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_ready) begin
            valid_reg <= q_valid;
        end
        if (q_ready && q_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule : ffp_back

`default_nettype wire
